// ----- hw/rtl/plc_pkg.sv -----
`timescale 1ns / 1ps

package plc_pkg;

  // controller modes
  typedef enum logic [2:0] {
    M_FIRST  = 3'd0,
    M_SECOND = 3'd1,
    M_OPTION = 3'd2,
    M_LOGIN  = 3'd3,
    M_CHANGE = 3'd4,
    M_MOTOR  = 3'd5,
    M_ALARM  = 3'd6
  } mode_t;

  // reply codes
  localparam logic [7:0] REPLY_UNMATCHED = 8'h00;
  localparam logic [7:0] REPLY_MATCHED   = 8'h01;
  localparam logic [7:0] REPLY_READY     = 8'h0F;

  // motor directions
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_ACW  = 2'd2;

  // register indexes on the config port
  localparam logic [2:0] REG_ALARM_TICKS  = 3'd0;
  localparam logic [2:0] REG_HOLD_TICK    = 3'd1;
  localparam logic [2:0] REG_REVERSE_TICK = 3'd2;
  localparam logic [2:0] REG_DONE_TICK    = 3'd3;
  localparam logic [2:0] REG_MAX_ATTEMPTS = 3'd4;
  localparam logic [2:0] REG_OPTION_BYTE  = 3'd5;

  // register reset values
  localparam logic [7:0] RST_ALARM_TICKS  = 8'd120;
  localparam logic [7:0] RST_HOLD_TICK    = 8'd30;
  localparam logic [7:0] RST_REVERSE_TICK = 8'd36;
  localparam logic [7:0] RST_DONE_TICK    = 8'd66;
  localparam logic [2:0] RST_MAX_ATTEMPTS = 3'd3;
  localparam logic [7:0] RST_OPTION_BYTE  = 8'd43;

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // one result word
  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_code;
    logic [1:0] motor_dir;
    logic       alarm_sound;
    logic       last;
  } result_t;

endpackage

// ----- hw/rtl/password_lock_controller.sv -----
`timescale 1ns / 1ps
// Password lock controller.
// Input channel (in_valid / in_stall): one word per accepted cycle, either a
// received byte (action 0, data_byte) or one timer tick (action 1).
// Output channel (out_valid / out_stall): one or two result words per input
// word; last marks the final word caused by an input. Words with reply_valid
// set carry a reply code to send back; every word shows motor_dir and
// alarm_sound as they stand after the input.
// Results are registered in the queue. Throughput: one input word per cycle
// while in_stall is low; a confirmed new password gives two result words, so
// the output port (one word per cycle) sets the rate then.
// Results go through a four-word queue; in_stall rises while fewer than two
// slots are free, so a stalled receiver backs up into the input after two
// or three words.
// Configuration is an APB-style port, registers at byte addresses 4*i.
// Reset (synchronous, rst high) restores the register defaults, empties the
// queue and starts collecting the first entry of a new password.
module password_lock_controller #(
  parameter int PASS_LEN = 5
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reply_valid,
  output logic [7:0]  reply_code,
  output logic [1:0]  motor_dir,
  output logic        alarm_sound,
  output logic        last
);
  import plc_pkg::*;

  localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;

  // config registers
  logic [7:0] alarm_ticks, hold_tick, reverse_tick, done_tick, open_option_byte;
  logic [2:0] max_attempts;
  logic [2:0] reg_index;
  logic       cfg_write;

  // controller state
  mode_t            mode, mode_next;
  logic [IDX_W-1:0] digit_index, digit_index_next;
  logic [7:0]       first_entry    [PASS_LEN];
  logic [7:0]       saved_password [PASS_LEN];
  logic             mismatch_seen, mismatch_seen_next;
  logic [2:0]       login_failures, login_failures_next;
  logic [2:0]       change_failures, change_failures_next;
  logic [7:0]       tick_count, tick_count_next;
  logic [1:0]       motor_state, motor_state_next;
  logic             buzzer_state, buzzer_state_next;

  // decoded conditions
  mode_t            cur_mode;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_mis;
  logic [7:0]       ref_byte;
  logic             digit_bad, digit_full, entry_bad;
  logic [7:0]       tick_inc;
  logic [2:0]       fail_inc;
  logic             alarm_hit;
  logic             store_digit, copy_entry;

  // results of this word
  result_t res0, res1;
  logic    two_results;

  // result queue
  result_t          fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic             in_accept, out_accept;
  logic [1:0]       push_cnt;

  // config port
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_ticks      <= RST_ALARM_TICKS;
      hold_tick        <= RST_HOLD_TICK;
      reverse_tick     <= RST_REVERSE_TICK;
      done_tick        <= RST_DONE_TICK;
      max_attempts     <= RST_MAX_ATTEMPTS;
      open_option_byte <= RST_OPTION_BYTE;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_ALARM_TICKS:  alarm_ticks      <= pwdata[7:0];
        REG_HOLD_TICK:    hold_tick        <= pwdata[7:0];
        REG_REVERSE_TICK: reverse_tick     <= pwdata[7:0];
        REG_DONE_TICK:    done_tick        <= pwdata[7:0];
        REG_MAX_ATTEMPTS: max_attempts     <= pwdata[2:0];
        REG_OPTION_BYTE:  open_option_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_index)
      REG_ALARM_TICKS:  prdata = {24'd0, alarm_ticks};
      REG_HOLD_TICK:    prdata = {24'd0, hold_tick};
      REG_REVERSE_TICK: prdata = {24'd0, reverse_tick};
      REG_DONE_TICK:    prdata = {24'd0, done_tick};
      REG_MAX_ATTEMPTS: prdata = {29'd0, max_attempts};
      REG_OPTION_BYTE:  prdata = {24'd0, open_option_byte};
      default:          prdata = 32'd0;
    endcase
  end

  // handshakes
  assign in_stall   = (count > CNT_W'(FIFO_DEPTH - 2));
  assign in_accept  = in_valid & ~in_stall;
  assign out_valid  = (count != '0);
  assign out_accept = out_valid & ~out_stall;

  // shared decode; an unused mode code acts as a fresh first entry
  always_comb begin
    if (mode > M_ALARM) begin
      cur_mode = M_FIRST;
      cur_idx  = '0;
      cur_mis  = 1'b0;
    end else begin
      cur_mode = mode;
      cur_idx  = digit_index;
      cur_mis  = mismatch_seen;
    end
    ref_byte   = (cur_mode == M_SECOND) ? first_entry[cur_idx] : saved_password[cur_idx];
    digit_bad  = (ref_byte != data_byte);
    digit_full = (cur_idx == IDX_W'(PASS_LEN - 1));
    entry_bad  = cur_mis | digit_bad;
    tick_inc   = tick_count + 8'd1;
    fail_inc   = ((cur_mode == M_LOGIN) ? login_failures : change_failures) + 3'd1;
    alarm_hit  = (fail_inc == max_attempts);
  end

  // next mode
  always_comb begin
    mode_next = cur_mode;
    if (action) begin
      if (cur_mode == M_MOTOR && tick_inc == done_tick) begin
        mode_next = M_OPTION;
      end else if (cur_mode == M_ALARM && tick_inc == alarm_ticks) begin
        mode_next = M_OPTION;
      end
    end else begin
      unique case (cur_mode)
        M_FIRST: begin
          if (digit_full) mode_next = M_SECOND;
        end
        M_SECOND: begin
          if (digit_full) mode_next = entry_bad ? M_FIRST : M_OPTION;
        end
        M_OPTION: begin
          mode_next = (data_byte == open_option_byte) ? M_LOGIN : M_CHANGE;
        end
        M_LOGIN: begin
          if (digit_full) begin
            if (!entry_bad)     mode_next = M_MOTOR;
            else if (alarm_hit) mode_next = M_ALARM;
          end
        end
        M_CHANGE: begin
          if (digit_full) begin
            if (!entry_bad)     mode_next = M_FIRST;
            else if (alarm_hit) mode_next = M_ALARM;
          end
        end
        default: ;
      endcase
    end
  end

  // state updates and result words
  always_comb begin
    digit_index_next     = cur_idx;
    mismatch_seen_next   = cur_mis;
    login_failures_next  = login_failures;
    change_failures_next = change_failures;
    tick_count_next      = tick_count;
    motor_state_next     = motor_state;
    buzzer_state_next    = buzzer_state;
    store_digit          = 1'b0;
    copy_entry           = 1'b0;
    two_results          = 1'b0;
    res0.reply_valid     = 1'b0;
    res0.reply_code      = 8'd0;

    if (action) begin
      // timer tick
      if (cur_mode == M_MOTOR) begin
        tick_count_next = tick_inc;
        if (tick_inc == hold_tick)    motor_state_next = DIR_STOP;
        if (tick_inc == reverse_tick) motor_state_next = DIR_ACW;
        if (tick_inc == done_tick) begin
          motor_state_next = DIR_STOP;
          tick_count_next  = 8'd0;
          res0.reply_valid = 1'b1;
          res0.reply_code  = REPLY_READY;
        end
      end else if (cur_mode == M_ALARM) begin
        tick_count_next = tick_inc;
        if (tick_inc == alarm_ticks) begin
          buzzer_state_next = 1'b0;
          tick_count_next   = 8'd0;
          res0.reply_valid  = 1'b1;
          res0.reply_code   = REPLY_READY;
        end
      end
    end else begin
      // received byte
      if (cur_mode == M_FIRST || cur_mode == M_SECOND ||
          cur_mode == M_LOGIN || cur_mode == M_CHANGE) begin
        digit_index_next = digit_full ? '0 : cur_idx + IDX_W'(1);
      end
      case (cur_mode) inside
        M_FIRST: begin
          store_digit = 1'b1;
          if (digit_full) mismatch_seen_next = 1'b0;
        end
        M_SECOND: begin
          if (digit_full) begin
            mismatch_seen_next = 1'b0;
            res0.reply_valid   = 1'b1;
            if (entry_bad) begin
              res0.reply_code = REPLY_UNMATCHED;
            end else begin
              copy_entry      = 1'b1;
              res0.reply_code = REPLY_MATCHED;
              two_results     = 1'b1;
            end
          end else begin
            mismatch_seen_next = entry_bad;
          end
        end
        M_OPTION: begin
          digit_index_next   = '0;
          mismatch_seen_next = 1'b0;
        end
        M_LOGIN, M_CHANGE: begin
          if (digit_full) begin
            mismatch_seen_next = 1'b0;
            res0.reply_valid   = 1'b1;
            if (entry_bad) begin
              res0.reply_code = REPLY_UNMATCHED;
              if (cur_mode == M_LOGIN) login_failures_next  = alarm_hit ? 3'd0 : fail_inc;
              else                     change_failures_next = alarm_hit ? 3'd0 : fail_inc;
              if (alarm_hit) begin
                buzzer_state_next = 1'b1;
                tick_count_next   = 8'd0;
              end
            end else begin
              res0.reply_code = REPLY_MATCHED;
              if (cur_mode == M_LOGIN) begin
                login_failures_next = 3'd0;
                motor_state_next    = DIR_CW;
                tick_count_next     = 8'd0;
              end else begin
                change_failures_next = 3'd0;
              end
            end
          end else begin
            mismatch_seen_next = entry_bad;
          end
        end
        default: ;
      endcase
    end

    res0.motor_dir   = motor_state_next;
    res0.alarm_sound = buzzer_state_next;
    res0.last        = ~two_results;
    res1.reply_valid = 1'b1;
    res1.reply_code  = REPLY_READY;
    res1.motor_dir   = motor_state_next;
    res1.alarm_sound = buzzer_state_next;
    res1.last        = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_FIRST;
      digit_index     <= '0;
      mismatch_seen   <= 1'b0;
      login_failures  <= 3'd0;
      change_failures <= 3'd0;
      tick_count      <= 8'd0;
      motor_state     <= DIR_STOP;
      buzzer_state    <= 1'b0;
    end else if (in_accept) begin
      mode            <= mode_next;
      digit_index     <= digit_index_next;
      mismatch_seen   <= mismatch_seen_next;
      login_failures  <= login_failures_next;
      change_failures <= change_failures_next;
      tick_count      <= tick_count_next;
      motor_state     <= motor_state_next;
      buzzer_state    <= buzzer_state_next;
    end
  end

  // password stores
  always_ff @(posedge clk) begin
    if (in_accept && !action && store_digit) begin
      first_entry[cur_idx] <= data_byte;
    end
    if (in_accept && copy_entry) begin
      for (int i = 0; i < PASS_LEN; i++) begin
        saved_password[i] <= first_entry[i];
      end
    end
  end

  // result queue
  assign push_cnt = in_accept ? (two_results ? 2'd2 : 2'd1) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_W'(out_accept);
      tail  <= tail + PTR_W'(push_cnt);
      count <= count + CNT_W'(push_cnt) - CNT_W'(out_accept);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fifo[tail] <= res0;
      if (two_results) fifo[tail + PTR_W'(1)] <= res1;
    end
  end

  // output word
  assign reply_valid = fifo[head].reply_valid;
  assign reply_code  = fifo[head].reply_code;
  assign motor_dir   = fifo[head].motor_dir;
  assign alarm_sound = fifo[head].alarm_sound;
  assign last        = fifo[head].last;

endmodule
